// ----- rtl/core/hmtp_pkg.sv -----
// Shared types and constants of the height-map text parser.
// Used by every module of the parser; depends on nothing else.
package hmtp_pkg;

   // Point numbers restart at zero when they reach this count (and at 16 bits in any case).
   localparam logic [32:0] MAX_POINTS = 33'd65536;

   localparam logic [31:0] COLOR_WHITE = 32'h00FF_FFFF;
   localparam logic [31:0] COLOR_SLOPE = 32'd838848;

   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_LC_A    = 8'h61;
   localparam logic [7:0] CHAR_LC_F    = 8'h66;
   localparam logic [7:0] CHAR_UC_A    = 8'h41;
   localparam logic [7:0] CHAR_UC_F    = 8'h46;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam logic [1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [1:0] CSR_CELL_STEP = 2'd2;

   localparam logic [31:0] RESET_ORIGIN_X  = 32'd0;
   localparam logic [31:0] RESET_ORIGIN_Y  = 32'd0;
   localparam logic [31:0] RESET_CELL_STEP = 32'd1;

   // Class of one request after decoding.
   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_DIGIT   = 3'd1,
      KIND_LETTER  = 3'd2,
      KIND_MINUS   = 3'd3,
      KIND_COMMA   = 3'd4,
      KIND_NEWLINE = 3'd5,
      KIND_SPACE   = 3'd6,
      KIND_OTHER   = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   value;   // hex value of a digit or letter
   } cmd_type;

   typedef struct packed {
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] height;
      logic [31:0] color;
      logic [15:0] point_number;
   } point_type;

   // Parse modes, one-hot.
   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_NUM     = 6'b000010,
      MODE_PRE1    = 6'b000100,
      MODE_PRE2    = 6'b001000,
      MODE_HEX     = 6'b010000,
      MODE_HEXSKIP = 6'b100000
   } mode_type;

   // Default colour from the height and the running product slope * height.
   function automatic logic [31:0] default_color(input logic [31:0] height,
                                                 input logic [31:0] product);
      logic [31:0] result;
      if (height == 32'd0 || height[31]) begin
         result = COLOR_WHITE;
      end else begin
         result = COLOR_WHITE - product;
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/height_map_text_parser.sv -----
// Height-map text parser, top level: front end, command queue, back end, result queue.
// Depends on hmtp_pkg, hmtp_front, hmtp_back and hmtp_rsp_queue.
// Throughput: one request per cycle while the result queue is not full, set by the state update of the back end.
// A point pushed out by a request passes through the command queue and then the result queue,
// whose head drives the result ports; it can be popped from there.
// Reset is synchronous and active high; it empties both queues and loads the reset values.
module height_map_text_parser (
   input  logic               clock,
   input  logic               reset,
   // Request side
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_op,
   input  logic [7:0]         req_char_code,
   // Result side
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_height,
   output logic [31:0]        rsp_color,
   output logic [15:0]        rsp_point_number,
   // Configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // Decoded requests travel from the front end to the back end through a
   // two-entry queue, so a stalled result side does not block decoding at once.
   logic                cmd_valid;
   logic                cmd_pop;
   hmtp_pkg::cmd_type   cmd_head;

   // Finished points go from the back end into the result queue.
   logic                pt_push;
   logic                pt_full;
   hmtp_pkg::point_type pt_data;
   hmtp_pkg::point_type rsp_head;

   // The front end classifies each byte (digit, hex letter, sign, comma and so on).
   hmtp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .cmd_valid     (cmd_valid),
      .cmd_head      (cmd_head),
      .cmd_pop       (cmd_pop)
   );

   // The back end holds the parse mode, coordinates and the point being built.
   // It takes a command only when the result queue has room for a point.
   hmtp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .pt_full          (pt_full),
      .pt_push          (pt_push),
      .pt_data          (pt_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // The result queue lets the back end keep working while a point waits.
   hmtp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .pt_push   (pt_push),
      .pt_data   (pt_data),
      .pt_full   (pt_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_point_x      = $signed(rsp_head.point_x);
   assign rsp_point_y      = $signed(rsp_head.point_y);
   assign rsp_height       = $signed(rsp_head.height);
   assign rsp_color        = rsp_head.color;
   assign rsp_point_number = rsp_head.point_number;

endmodule

// ----- rtl/core/hmtp_front.sv -----
// Front end of the height-map text parser: decodes each request and queues it.
// Depends on hmtp_pkg.
module hmtp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_op,
   input  logic [7:0]        req_char_code,
   output logic              cmd_valid,
   output hmtp_pkg::cmd_type cmd_head,
   input  logic              cmd_pop
);

   hmtp_pkg::cmd_type decoded;
   hmtp_pkg::cmd_type queue_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_ok;

   always_comb begin
      decoded.value = req_char_code[3:0];
      decoded.kind  = hmtp_pkg::KIND_OTHER;
      if (req_op) begin
         decoded.kind = hmtp_pkg::KIND_END;
      end else begin
         case (req_char_code) inside
            [hmtp_pkg::CHAR_0:hmtp_pkg::CHAR_9]: begin
               decoded.kind = hmtp_pkg::KIND_DIGIT;
            end
            [hmtp_pkg::CHAR_LC_A:hmtp_pkg::CHAR_LC_F]: begin
               decoded.kind  = hmtp_pkg::KIND_LETTER;
               decoded.value = 4'(req_char_code - hmtp_pkg::CHAR_LC_A) + 4'd10;
            end
            [hmtp_pkg::CHAR_UC_A:hmtp_pkg::CHAR_UC_F]: begin
               decoded.kind  = hmtp_pkg::KIND_LETTER;
               decoded.value = 4'(req_char_code - hmtp_pkg::CHAR_UC_A) + 4'd10;
            end
            hmtp_pkg::CHAR_MINUS:   decoded.kind = hmtp_pkg::KIND_MINUS;
            hmtp_pkg::CHAR_COMMA:   decoded.kind = hmtp_pkg::KIND_COMMA;
            hmtp_pkg::CHAR_NEWLINE: decoded.kind = hmtp_pkg::KIND_NEWLINE;
            hmtp_pkg::CHAR_SPACE:   decoded.kind = hmtp_pkg::KIND_SPACE;
            default:                decoded.kind = hmtp_pkg::KIND_OTHER;
         endcase
      end
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- rtl/core/hmtp_back.sv -----
// Back end of the height-map text parser: runs the parse state and builds points.
// Depends on hmtp_pkg.
module hmtp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  hmtp_pkg::cmd_type   cmd_head,
   output logic                cmd_pop,
   input  logic                pt_full,
   output logic                pt_push,
   output hmtp_pkg::point_type pt_data,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   hmtp_pkg::mode_type mode_ff, mode_in;
   logic        neg_ff, neg_in;
   logic [31:0] height_ff, height_in;     // signed height of the held point
   logic [31:0] prod_ff, prod_in;         // slope * height, wrapped
   logic [31:0] color_ff, color_in;       // explicit colour, also the hex accumulator
   logic        explicit_ff, explicit_in;
   logic [31:0] cur_x_ff, cur_x_in;
   logic [31:0] cur_y_ff, cur_y_in;
   logic [15:0] count_ff, count_in;
   logic        held_valid_ff, held_valid_in;
   logic [31:0] held_x_ff, held_x_in;
   logic [31:0] held_y_ff, held_y_in;
   logic [15:0] held_num_ff, held_num_in;
   logic [31:0] origin_x_ff, origin_x_in;
   logic [31:0] origin_y_ff, origin_y_in;
   logic [31:0] step_ff, step_in;

   logic        fire;
   logic        idle_byte;
   logic        start_point;
   logic        is_digit;
   logic        is_hex;
   logic        is_break;
   logic [31:0] digit_w;
   logic [31:0] slope_digit;
   logic [16:0] count_next;

   assign fire     = cmd_valid && !pt_full;
   assign cmd_pop  = fire;
   assign is_digit = (cmd_head.kind == hmtp_pkg::KIND_DIGIT);
   assign is_hex   = is_digit || (cmd_head.kind == hmtp_pkg::KIND_LETTER);
   assign is_break = (cmd_head.kind == hmtp_pkg::KIND_SPACE)
                  || (cmd_head.kind == hmtp_pkg::KIND_NEWLINE);
   assign digit_w     = 32'(cmd_head.value);
   assign slope_digit = hmtp_pkg::COLOR_SLOPE * digit_w;
   assign count_next  = {1'b0, count_ff} + 17'd1;

   always_comb begin
      mode_in       = mode_ff;
      neg_in        = neg_ff;
      height_in     = height_ff;
      prod_in       = prod_ff;
      color_in      = color_ff;
      explicit_in   = explicit_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      count_in      = count_ff;
      held_valid_in = held_valid_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_num_in   = held_num_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      step_in       = step_ff;
      idle_byte     = 1'b0;
      start_point   = 1'b0;

      if (fire) begin
         if (cmd_head.kind == hmtp_pkg::KIND_END) begin
            held_valid_in = 1'b0;
            mode_in       = hmtp_pkg::MODE_IDLE;
            neg_in        = 1'b0;
            height_in     = 32'd0;
            prod_in       = 32'd0;
         end else begin
            case (mode_ff)
               hmtp_pkg::MODE_PRE1: mode_in = hmtp_pkg::MODE_PRE2;
               hmtp_pkg::MODE_PRE2: mode_in = hmtp_pkg::MODE_HEX;
               hmtp_pkg::MODE_HEX: begin
                  if (is_hex) begin
                     color_in = {color_ff[27:0], cmd_head.value};
                  end else if (is_break) begin
                     mode_in   = hmtp_pkg::MODE_IDLE;
                     idle_byte = 1'b1;
                  end else begin
                     mode_in = hmtp_pkg::MODE_HEXSKIP;
                  end
               end
               hmtp_pkg::MODE_HEXSKIP: begin
                  if (is_break) begin
                     mode_in   = hmtp_pkg::MODE_IDLE;
                     idle_byte = 1'b1;
                  end
               end
               hmtp_pkg::MODE_NUM: begin
                  if (is_digit) begin
                     // -(10a + d) = 10(-a) - d, so the signed value extends directly.
                     height_in = {height_ff[28:0], 3'b000} + {height_ff[30:0], 1'b0}
                               + (neg_ff ? (32'd0 - digit_w) : digit_w);
                     prod_in   = {prod_ff[28:0], 3'b000} + {prod_ff[30:0], 1'b0}
                               + (neg_ff ? (32'd0 - slope_digit) : slope_digit);
                  end else begin
                     mode_in   = hmtp_pkg::MODE_IDLE;
                     idle_byte = 1'b1;
                  end
               end
               default: idle_byte = 1'b1;
            endcase

            if (idle_byte) begin
               if (is_digit || cmd_head.kind == hmtp_pkg::KIND_MINUS) begin
                  start_point   = 1'b1;
                  cur_x_in      = cur_x_ff + step_ff;
                  held_x_in     = cur_x_ff + step_ff;
                  held_y_in     = cur_y_ff;
                  held_num_in   = count_ff;
                  held_valid_in = 1'b1;
                  explicit_in   = 1'b0;
                  if (33'(count_next) >= hmtp_pkg::MAX_POINTS) begin
                     count_in = 16'd0;
                  end else begin
                     count_in = count_next[15:0];
                  end
                  neg_in    = !is_digit;
                  height_in = is_digit ? digit_w : 32'd0;
                  prod_in   = is_digit ? slope_digit : 32'd0;
                  mode_in   = hmtp_pkg::MODE_NUM;
               end else if (cmd_head.kind == hmtp_pkg::KIND_COMMA) begin
                  color_in    = 32'd0;
                  explicit_in = 1'b1;
                  mode_in     = hmtp_pkg::MODE_PRE1;
               end else if (cmd_head.kind == hmtp_pkg::KIND_NEWLINE) begin
                  cur_x_in = origin_x_ff;
                  cur_y_in = cur_y_ff + step_ff;
               end
            end
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            hmtp_pkg::CSR_ORIGIN_X: begin
               origin_x_in = csr_wdata;
               cur_x_in    = csr_wdata;
            end
            hmtp_pkg::CSR_ORIGIN_Y: begin
               origin_y_in = csr_wdata;
               cur_y_in    = csr_wdata;
            end
            hmtp_pkg::CSR_CELL_STEP: step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign pt_push = fire && held_valid_ff
                 && ((cmd_head.kind == hmtp_pkg::KIND_END) || start_point);

   always_comb begin
      pt_data.point_x      = held_x_ff;
      pt_data.point_y      = held_y_ff;
      pt_data.height       = height_ff;
      pt_data.color        = explicit_ff ? color_ff
                                         : hmtp_pkg::default_color(height_ff, prod_ff);
      pt_data.point_number = held_num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= hmtp_pkg::MODE_IDLE;
         neg_ff        <= 1'b0;
         height_ff     <= 32'd0;
         prod_ff       <= 32'd0;
         explicit_ff   <= 1'b0;
         cur_x_ff      <= hmtp_pkg::RESET_ORIGIN_X;
         cur_y_ff      <= hmtp_pkg::RESET_ORIGIN_Y;
         count_ff      <= 16'd0;
         held_valid_ff <= 1'b0;
         origin_x_ff   <= hmtp_pkg::RESET_ORIGIN_X;
         origin_y_ff   <= hmtp_pkg::RESET_ORIGIN_Y;
         step_ff       <= hmtp_pkg::RESET_CELL_STEP;
      end else begin
         mode_ff       <= mode_in;
         neg_ff        <= neg_in;
         height_ff     <= height_in;
         prod_ff       <= prod_in;
         explicit_ff   <= explicit_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      held_x_ff   <= held_x_in;
      held_y_ff   <= held_y_in;
      held_num_ff <= held_num_in;
   end

`ifndef SYNTH
   // A number is only ever read while its point is held.
   a_num_has_point: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == hmtp_pkg::MODE_NUM) |-> held_valid_ff)
      else $error("number mode without a held point");

   // An end request leaves nothing held and the parser idle.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd_head.kind == hmtp_pkg::KIND_END)
      |=> (!held_valid_ff && mode_ff == hmtp_pkg::MODE_IDLE))
      else $error("end request did not clear the held point");

   // The first prefix byte is always followed by the second, unless an end request comes.
   a_prefix_order: assert property (@(posedge clock) disable iff (reset)
      (fire && mode_ff == hmtp_pkg::MODE_PRE1 && cmd_head.kind != hmtp_pkg::KIND_END)
      |=> (mode_ff == hmtp_pkg::MODE_PRE2))
      else $error("prefix skip out of order");

   // A new point leaves a point held and the point counter moved on.
   a_start_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && start_point) |=> (held_valid_ff && held_num_ff == $past(count_ff)))
      else $error("new point not captured");
`endif

endmodule

// ----- rtl/core/hmtp_rsp_queue.sv -----
// Two-entry result queue of the height-map text parser.
// Depends on hmtp_pkg.
module hmtp_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                pt_push,
   input  hmtp_pkg::point_type pt_data,
   output logic                pt_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output hmtp_pkg::point_type rsp_head
);

   hmtp_pkg::point_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop_ok;

   assign pt_full   = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_head  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ pt_push;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, pt_push} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_push) begin
         queue_ff[wr_ptr_ff] <= pt_data;
      end
   end

endmodule
